@@ rtl/idll_pkg.sv @@
`timescale 1ns / 1ps
package idll_pkg;

	// Request codes carried on the input tuser
	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_READ   = 3'd2,
		ACT_WALK   = 3'd3,
		ACT_INDEX  = 3'd4
	} act_t;

	// Completion codes carried on the output tuser
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_SENTINEL = 2'd2
	} status_t;

	localparam int FREE_HEAD = 0;
	localparam int USED_HEAD = 1;
	localparam int WALK_W    = 11;

	localparam logic [63:0] SENTINEL_VALUE = 64'h0000_0000_BEBE_BEBE;

	typedef struct packed {
		logic [2:0]         action;
		logic [9:0]         slot;
		logic signed [31:0] ins_value;
		logic signed [10:0] steps;
		logic [9:0]         list_index;
	} req_t;

	typedef struct packed {
		logic [9:0]         result_slot;
		logic signed [31:0] read_value;
		logic [9:0]         item_count;
		logic [1:0]         status;
	} res_t;

endpackage

@@ rtl/idll_ram.sv @@
`timescale 1ns / 1ps
module idll_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, returns the old word on a same-cycle write
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/idll_ctrl.sv @@
`timescale 1ns / 1ps
module idll_ctrl
	import idll_pkg::*;
#(
	parameter int SLOT_COUNT = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  req_t                          req,
	input  logic                          out_free,
	output logic                          out_valid,
	output res_t                          res,
	output logic                          nxt_we,
	output logic [$clog2(SLOT_COUNT)-1:0] nxt_waddr,
	output logic [$clog2(SLOT_COUNT)-1:0] nxt_wdata,
	output logic [$clog2(SLOT_COUNT)-1:0] nxt_raddr,
	input  logic [$clog2(SLOT_COUNT)-1:0] nxt_rdata,
	output logic                          prv_we,
	output logic [$clog2(SLOT_COUNT)-1:0] prv_waddr,
	output logic [$clog2(SLOT_COUNT)-1:0] prv_wdata,
	output logic [$clog2(SLOT_COUNT)-1:0] prv_raddr,
	input  logic [$clog2(SLOT_COUNT)-1:0] prv_rdata,
	output logic                          val_we,
	output logic [$clog2(SLOT_COUNT)-1:0] val_waddr,
	output logic [DATA_WIDTH-1:0]         val_wdata,
	output logic [$clog2(SLOT_COUNT)-1:0] val_raddr,
	input  logic [DATA_WIDTH-1:0]         val_rdata
);

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int UW = (AW + 1 > WALK_W) ? AW + 1 : WALK_W;

	localparam logic [AW-1:0] FREE_A = AW'(FREE_HEAD);
	localparam logic [AW-1:0] USED_A = AW'(USED_HEAD);
	localparam logic [AW-1:0] LAST_A = AW'(SLOT_COUNT - 1);
	localparam logic [AW-1:0] FULL_A = AW'(SLOT_COUNT - 2);
	localparam logic [AW-1:0] TWO_A  = AW'(2);

	typedef enum logic [18:0] {
		S_INIT  = 19'h00001,
		S_IDLE  = 19'h00002,
		S_RED   = 19'h00004,
		S_DISP  = 19'h00008,
		S_INS1  = 19'h00010,
		S_INS2  = 19'h00020,
		S_INS3  = 19'h00040,
		S_INS4  = 19'h00080,
		S_INS5  = 19'h00100,
		S_RM1   = 19'h00200,
		S_RM2   = 19'h00400,
		S_RM3   = 19'h00800,
		S_RM4   = 19'h01000,
		S_WALK  = 19'h02000,
		S_WSTEP = 19'h04000,
		S_IDX1  = 19'h08000,
		S_VAL   = 19'h10000,
		S_VAL2  = 19'h20000,
		S_DONE  = 19'h40000
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           init_q;
	logic [2:0]              act_q;
	logic [UW-1:0]           red_q;
	logic signed [31:0]      nv_q;
	logic signed [10:0]      steps_q;
	logic [9:0]              idx_q;
	logic [AW-1:0]           n_q;
	logic [AW-1:0]           before_q;
	logic [AW-1:0]           cur_q;
	logic [WALK_W-1:0]       cnt_q;
	logic                    dir_q;
	logic [AW-1:0]           count_q;
	logic [AW-1:0]           rslot_q;
	logic [DATA_WIDTH-1:0]   rval_q;
	logic [1:0]              status_q;

	logic [AW-1:0]           slot;
	logic [UW-1:0]           alu_a;
	logic [UW-1:0]           alu_b;
	logic                    alu_sub;
	logic [UW:0]             alu_res;
	logic [AW-1:0]           init_next;
	logic [AW-1:0]           init_prev;

	assign slot = red_q[AW-1:0];

	// shared adder: modulo reduction, walk countdown, item count
	assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                         : ({1'b0, alu_a} + {1'b0, alu_b});

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_RED: begin
				alu_a   = red_q;
				alu_b   = UW'(SLOT_COUNT);
				alu_sub = 1'b1;
			end
			S_WALK: begin
				alu_a   = UW'(cnt_q);
				alu_b   = UW'(1);
				alu_sub = 1'b1;
			end
			S_INS5: begin
				alu_a = UW'(count_q);
				alu_b = UW'(1);
			end
			S_RM4: begin
				alu_a   = UW'(count_q);
				alu_b   = UW'(1);
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// reset image of the free chain and used sentinel
	always_comb begin
		if (init_q == FREE_A) begin
			init_next = TWO_A;
			init_prev = LAST_A;
		end else if (init_q == USED_A) begin
			init_next = USED_A;
			init_prev = USED_A;
		end else begin
			init_next = (init_q == LAST_A) ? FREE_A : init_q + AW'(1);
			init_prev = (init_q == TWO_A) ? FREE_A : init_q - AW'(1);
		end
	end

	// memory port steering
	always_comb begin
		nxt_we    = 1'b0;
		nxt_waddr = '0;
		nxt_wdata = '0;
		nxt_raddr = '0;
		prv_we    = 1'b0;
		prv_waddr = '0;
		prv_wdata = '0;
		prv_raddr = '0;
		val_we    = 1'b0;
		val_waddr = '0;
		val_wdata = '0;
		val_raddr = cur_q;
		unique case (state_q)
			S_INIT: begin
				nxt_we    = 1'b1;
				nxt_waddr = init_q;
				nxt_wdata = init_next;
				prv_we    = 1'b1;
				prv_waddr = init_q;
				prv_wdata = init_prev;
				val_we    = 1'b1;
				val_waddr = init_q;
			end
			S_DISP: begin
				case (act_q)
					ACT_INSERT: nxt_raddr = FREE_A;
					ACT_REMOVE: begin
						nxt_raddr = slot;
						prv_raddr = slot;
					end
					ACT_INDEX:  nxt_raddr = USED_A;
					default: begin
					end
				endcase
			end
			S_INS1: nxt_raddr = nxt_rdata;
			S_INS2: begin
				prv_we    = 1'b1;
				prv_waddr = nxt_rdata;
				prv_wdata = FREE_A;
				nxt_we    = 1'b1;
				nxt_waddr = FREE_A;
				nxt_wdata = nxt_rdata;
			end
			S_INS3: prv_raddr = slot;
			S_INS4: begin
				nxt_we    = 1'b1;
				nxt_waddr = prv_rdata;
				nxt_wdata = n_q;
				prv_we    = 1'b1;
				prv_waddr = slot;
				prv_wdata = n_q;
			end
			S_INS5: begin
				nxt_we    = 1'b1;
				nxt_waddr = n_q;
				nxt_wdata = slot;
				prv_we    = 1'b1;
				prv_waddr = n_q;
				prv_wdata = before_q;
				val_we    = 1'b1;
				val_waddr = n_q;
				val_wdata = DATA_WIDTH'(nv_q);
			end
			S_RM1: begin
				nxt_we    = 1'b1;
				nxt_waddr = prv_rdata;
				nxt_wdata = nxt_rdata;
				prv_we    = 1'b1;
				prv_waddr = nxt_rdata;
				prv_wdata = prv_rdata;
			end
			S_RM2: prv_raddr = FREE_A;
			S_RM3: begin
				prv_we    = 1'b1;
				prv_waddr = slot;
				prv_wdata = prv_rdata;
				nxt_we    = 1'b1;
				nxt_waddr = slot;
				nxt_wdata = FREE_A;
			end
			S_RM4: begin
				nxt_we    = 1'b1;
				nxt_waddr = before_q;
				nxt_wdata = slot;
				prv_we    = 1'b1;
				prv_waddr = FREE_A;
				prv_wdata = slot;
			end
			S_WALK: begin
				nxt_raddr = cur_q;
				prv_raddr = cur_q;
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE) && out_free;

	assign res.result_slot = 10'(rslot_q);
	assign res.read_value  = 32'(rval_q);
	assign res.item_count  = 10'(count_q);
	assign res.status      = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == LAST_A) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (alu_res[UW]) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (act_q)
						ACT_INSERT: state_q <= S_INS1;
						ACT_REMOVE: state_q <= (slot < TWO_A) ? S_DONE : S_RM1;
						ACT_READ:   state_q <= S_VAL;
						ACT_WALK:   state_q <= S_WALK;
						ACT_INDEX:  state_q <= S_IDX1;
						default:    state_q <= S_DONE;
					endcase
				end
				S_INS1: begin
					if (nxt_rdata < TWO_A || count_q >= FULL_A) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_INS2;
					end
				end
				S_INS2: state_q <= S_INS3;
				S_INS3: state_q <= S_INS4;
				S_INS4: state_q <= S_INS5;
				S_INS5: begin
					count_q <= alu_res[AW-1:0];
					state_q <= S_DONE;
				end
				S_RM1: state_q <= S_RM2;
				S_RM2: state_q <= S_RM3;
				S_RM3: state_q <= S_RM4;
				S_RM4: begin
					if (count_q != '0) begin
						count_q <= alu_res[AW-1:0];
					end
					state_q <= S_DONE;
				end
				S_WALK:  state_q <= (cnt_q == '0) ? S_VAL : S_WSTEP;
				S_WSTEP: state_q <= S_WALK;
				S_IDX1:  state_q <= S_WALK;
				S_VAL:   state_q <= S_VAL2;
				S_VAL2:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q   <= req.action;
				red_q   <= UW'(req.slot);
				nv_q    <= req.ins_value;
				steps_q <= req.steps;
				idx_q   <= req.list_index;
			end
			S_RED: begin
				if (!alu_res[UW]) begin
					red_q <= alu_res[UW-1:0];
				end
			end
			S_DISP: begin
				rslot_q  <= '0;
				rval_q   <= '0;
				status_q <= ST_OK;
				cur_q    <= slot;
				dir_q    <= steps_q[10];
				cnt_q    <= steps_q[10] ? WALK_W'(-steps_q) : WALK_W'(steps_q);
				if (act_q == ACT_REMOVE && slot < TWO_A) begin
					status_q <= ST_SENTINEL;
				end
			end
			S_INS1: begin
				n_q <= nxt_rdata;
				if (nxt_rdata < TWO_A || count_q >= FULL_A) begin
					status_q <= ST_FULL;
				end
			end
			S_INS4: before_q <= prv_rdata;
			S_INS5: rslot_q <= n_q;
			S_RM1:  before_q <= before_q;
			S_RM3:  before_q <= prv_rdata;
			S_WALK: begin
				if (cnt_q != '0) begin
					cnt_q <= alu_res[WALK_W-1:0];
				end
			end
			S_WSTEP: cur_q <= dir_q ? prv_rdata : nxt_rdata;
			S_IDX1: begin
				cur_q <= nxt_rdata;
				cnt_q <= WALK_W'(idx_q);
				dir_q <= 1'b0;
			end
			S_VAL: rslot_q <= cur_q;
			S_VAL2: begin
				rval_q <= (cur_q < TWO_A) ? DATA_WIDTH'(SENTINEL_VALUE) : val_rdata;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/indexed_doubly_linked_list_engine.sv @@
`timescale 1ns / 1ps
// Before dispatch, the slot number is reduced modulo SLOT_COUNT by repeated subtraction;
// walk and index reads follow one link per S_WALK/S_WSTEP pair.
// One item at a time: the next item is taken the cycle after its result is loaded.
// Reset: async, active low; then an init pass rebuilds the link and value
// memories one slot per cycle with s_axis_tready held low.
module indexed_doubly_linked_list_engine
	import idll_pkg::*;
#(
	parameter int SLOT_COUNT = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// slot[9:0], ins_value[41:10], steps[52:42], list_index[62:53], zero pad[63]
	input  logic [63:0] s_axis_tdata,
	// action[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_slot[9:0], read_value[41:10], item_count[51:42], zero pad[55:52]
	output logic [55:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]  m_axis_tuser
);

	localparam int AW = $clog2(SLOT_COUNT);

	req_t                  req;
	res_t                  res;
	logic                  out_free;
	logic                  out_valid;

	logic                  nxt_we;
	logic [AW-1:0]         nxt_waddr;
	logic [AW-1:0]         nxt_wdata;
	logic [AW-1:0]         nxt_raddr;
	logic [AW-1:0]         nxt_rdata;
	logic                  prv_we;
	logic [AW-1:0]         prv_waddr;
	logic [AW-1:0]         prv_wdata;
	logic [AW-1:0]         prv_raddr;
	logic [AW-1:0]         prv_rdata;
	logic                  val_we;
	logic [AW-1:0]         val_waddr;
	logic [DATA_WIDTH-1:0] val_wdata;
	logic [AW-1:0]         val_raddr;
	logic [DATA_WIDTH-1:0] val_rdata;

	logic                  m_valid_q;
	logic [55:0]           m_data_q;
	logic [1:0]            m_user_q;

	// unpack the request item
	assign req.action     = s_axis_tuser;
	assign req.slot       = s_axis_tdata[9:0];
	assign req.ins_value  = s_axis_tdata[41:10];
	assign req.steps      = s_axis_tdata[52:42];
	assign req.list_index = s_axis_tdata[62:53];

	// the result register frees up when it is empty or being drained this cycle
	assign out_free = !m_valid_q || m_axis_tready;

	idll_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.req       (req),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res       (res),
		.nxt_we    (nxt_we),
		.nxt_waddr (nxt_waddr),
		.nxt_wdata (nxt_wdata),
		.nxt_raddr (nxt_raddr),
		.nxt_rdata (nxt_rdata),
		.prv_we    (prv_we),
		.prv_waddr (prv_waddr),
		.prv_wdata (prv_wdata),
		.prv_raddr (prv_raddr),
		.prv_rdata (prv_rdata),
		.val_we    (val_we),
		.val_waddr (val_waddr),
		.val_wdata (val_wdata),
		.val_raddr (val_raddr),
		.val_rdata (val_rdata)
	);

	// next links, one entry per slot
	idll_ram #(
		.WIDTH (AW),
		.DEPTH (SLOT_COUNT)
	) u_next (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (nxt_raddr),
		.rdata (nxt_rdata)
	);

	// previous links
	idll_ram #(
		.WIDTH (AW),
		.DEPTH (SLOT_COUNT)
	) u_prev (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.raddr (prv_raddr),
		.rdata (prv_rdata)
	);

	// stored values; for sentinel slots the word read here is replaced by the sentinel pattern
	idll_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (SLOT_COUNT)
	) u_value (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// output register: hold the item until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid) begin
			m_data_q <= {4'b0, res.item_count, res.read_value, res.result_slot};
			m_user_q <= res.status;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

@@ rtl/idll_chk.sv @@
`timescale 1ns / 1ps
module idll_chk
	import idll_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// one item in flight: the sequencer drops ready right after taking an item
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an item is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result item changed");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_FULL) |-> (m_axis_tdata[41:0] == '0))
		else $error("full insert reported a slot or value");

	a_sent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_SENTINEL) |-> (m_axis_tdata[41:0] == '0))
		else $error("sentinel remove reported a slot or value");

endmodule

bind indexed_doubly_linked_list_engine idll_chk u_idll_chk (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import idll_pkg::*;

	localparam int SLOT_COUNT = 1024;
	localparam int DATA_WIDTH = 32;
	// Generous ceiling: reset, the link-clearing pass, ~750 items with stalls on
	// both sides, and a few dozen long walks.
	localparam int CYCLE_LIMIT = 1000000;
	// Enough for the slowest item (walk of 1024 links) to show up if it is stray.
	localparam int DRAIN_CYCLES = 2100;

	localparam logic [31:0] SENT = SENTINEL_VALUE[31:0];

	// Action codes the block does not know; they must change nothing
	localparam logic [2:0] ACT_RSVD5 = 3'd5;
	localparam logic [2:0] ACT_RSVD6 = 3'd6;
	localparam logic [2:0] ACT_RSVD7 = 3'd7;

	// One request plus, where it is obvious, the reply typed in by hand
	typedef struct packed {
		logic [2:0]         act;
		logic [9:0]         slot;
		logic [31:0]        val;
		logic signed [10:0] steps;
		logic [9:0]         idx;
		bit                 typed;
		res_t               want;
	} step_row_t;

	localparam res_t NO_WANT = '0;
	localparam int SCRIPT_LEN = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// slot[9:0], ins_value[41:10], steps[52:42], list_index[62:53], zero pad[63]
	logic [63:0] s_axis_tdata = '0;
	// action[2:0]
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// result_slot[9:0], read_value[41:10], item_count[51:42], zero pad[55:52]
	logic [55:0] m_axis_tdata;
	// status[1:0]
	logic [1:0]  m_axis_tuser;

	// Mirror of the list storage, kept in step with every accepted item
	logic [31:0] slot_value [0:SLOT_COUNT-1];
	logic [9:0]  link_next [0:SLOT_COUNT-1];
	logic [9:0]  link_prev [0:SLOT_COUNT-1];
	int          live_count;

	res_t        replies_due [$];
	step_row_t   script [SCRIPT_LEN];
	bit          gaps_on = 1'b1;
	int          mismatches = 0;
	int          full_hits = 0;
	int          cycles = 0;
	int          hold_left = 0;

	always #2 clk = ~clk;

	indexed_doubly_linked_list_engine #(
		.SLOT_COUNT(SLOT_COUNT),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("%0t mismatch in %s: got %h, want %h", $time, what, got, want);
	endtask

	// Follow n links from s: next links for n >= 0, previous links otherwise
	function automatic logic [9:0] follow_links(input logic [9:0] s, input int n);
		logic [9:0] at;
		at = s;
		if (n >= 0) begin
			repeat (n) at = link_next[at];
		end else begin
			repeat (-n) at = link_prev[at];
		end
		return at;
	endfunction

	// Slot reached k next links from the used-list sentinel (k = 0 gives the sentinel)
	function automatic logic [9:0] used_slot_at(input int k);
		return follow_links(10'(USED_HEAD), k);
	endfunction

	// Apply one request to the mirrored list and work out the reply it owes
	task automatic list_apply(input step_row_t rq, output res_t rs);
		logic [9:0] taken, after_taken, prior, after, tail, reached;
		rs = '0;
		case (rq.act)
			ACT_INSERT: begin
				taken = link_next[FREE_HEAD];
				if (taken < 2 || live_count >= SLOT_COUNT - 2) begin
					rs.status = ST_FULL;
				end else begin
					// unhook the free head first, then splice it in ahead of the target
					after_taken = link_next[taken];
					link_prev[after_taken] = 10'(FREE_HEAD);
					link_next[FREE_HEAD] = after_taken;
					prior = link_prev[rq.slot];
					link_next[prior] = taken;
					link_prev[rq.slot] = taken;
					link_next[taken] = rq.slot;
					link_prev[taken] = prior;
					slot_value[taken] = rq.val;
					live_count++;
					rs.result_slot = taken;
				end
			end
			ACT_REMOVE: begin
				if (rq.slot < 2) begin
					rs.status = ST_SENTINEL;
				end else begin
					// unlink, then park the slot at the free-list tail
					after = link_next[rq.slot];
					prior = link_prev[rq.slot];
					link_next[prior] = after;
					link_prev[after] = prior;
					tail = link_prev[FREE_HEAD];
					link_prev[rq.slot] = tail;
					link_next[rq.slot] = 10'(FREE_HEAD);
					link_next[tail] = rq.slot;
					link_prev[FREE_HEAD] = rq.slot;
					if (live_count > 0)
						live_count--;
				end
			end
			ACT_READ: begin
				rs.result_slot = rq.slot;
				rs.read_value = slot_value[rq.slot];
			end
			ACT_WALK: begin
				reached = follow_links(rq.slot, int'(rq.steps));
				rs.result_slot = reached;
				rs.read_value = slot_value[reached];
			end
			ACT_INDEX: begin
				reached = follow_links(link_next[USED_HEAD], int'(rq.idx));
				rs.result_slot = reached;
				rs.read_value = slot_value[reached];
			end
			default: begin
			end
		endcase
		rs.item_count = live_count[9:0];
	endtask

	// Offer one item, wait for it to be taken, then log the reply it owes.
	// Returns on the accepting edge with tvalid still high.
	task automatic send_request(input step_row_t row);
		res_t predicted;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, row.idx, row.steps, row.val, row.slot};
		s_axis_tuser  <= row.act;
		do @(posedge clk); while (!s_axis_tready);
		list_apply(row, predicted);
		if (predicted.status == ST_FULL)
			full_hits++;
		replies_due.push_back(row.typed ? row.want : predicted);
	endtask

	// Build one random item. Most target slots come from the live list so that
	// inserts and removes keep it well formed; a small share is noise.
	task automatic issue_random(input int ins_pct, input int rem_pct);
		step_row_t row;
		int pick, cap, sv;
		row = '0;
		case ($urandom_range(0, 9))
			0: row.val = 32'h7FFF_FFFF;
			1: row.val = 32'h8000_0000;
			default: row.val = $urandom;
		endcase
		row.steps = 11'($urandom);
		row.idx = 10'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < ins_pct) begin
			row.act = ACT_INSERT;
			row.slot = used_slot_at($urandom_range(0, live_count));
		end else if (pick < ins_pct + rem_pct) begin
			row.act = ACT_REMOVE;
			row.slot = (live_count > 0) ? used_slot_at($urandom_range(1, live_count))
				: 10'($urandom);
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: begin
					row.act = ACT_READ;
					row.slot = used_slot_at($urandom_range(0, live_count));
				end
				5, 6, 7, 8, 9: begin
					row.act = ACT_WALK;
					row.slot = used_slot_at($urandom_range(0, live_count));
					// keep most walks short, since a walk follows each link in turn
					if ($urandom_range(0, 24) != 0) begin
						sv = $urandom_range(0, 24) - 12;
						row.steps = 11'(sv);
					end
				end
				10, 11, 12, 13, 14: begin
					row.act = ACT_INDEX;
					cap = (live_count + 1 < 40) ? live_count + 1 : 40;
					if ($urandom_range(0, 24) != 0)
						row.idx = 10'($urandom_range(0, cap));
				end
				15, 16: begin
					row.act = ACT_READ;
					row.slot = 10'($urandom);
				end
				17: begin
					row.act = 3'(ACT_RSVD5 + $urandom_range(0, 2));
					row.slot = 10'($urandom);
				end
				18: begin
					// sentinel half the time, otherwise any slot, used or free
					row.act = ACT_REMOVE;
					row.slot = $urandom_range(0, 1) ? 10'($urandom_range(0, 1))
						: 10'($urandom);
				end
				default: begin
					row.act = ACT_INSERT;
					row.slot = 10'($urandom);
				end
			endcase
		end
		send_request(row);
	endtask

	// Count cycles and bail out if the run hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Reply side: check each accepted item, then decide tready for the next edge
	always @(posedge clk) begin : reply_check
		res_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[9:0], m_axis_tdata[41:10], m_axis_tdata[51:42],
				m_axis_tuser};
			if (replies_due.size() == 0) begin
				report_mismatch("reply with none due, result_slot",
					32'(got.result_slot), 32'd0);
			end else begin
				want = replies_due.pop_front();
				if (got.result_slot !== want.result_slot)
					report_mismatch("result_slot", 32'(got.result_slot),
						32'(want.result_slot));
				if (got.read_value !== want.read_value)
					report_mismatch("read_value", got.read_value, want.read_value);
				if (got.item_count !== want.item_count)
					report_mismatch("item_count", 32'(got.item_count),
						32'(want.item_count));
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
			end
		end
		// stall in bursts at random, with hold_left counting down
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			hold_left <= $urandom_range(0, 6);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		// Mirror the reset state: free chain 0,2,3..last, used sentinel on itself
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_value[i] = '0;
			link_next[i] = (i + 1 < SLOT_COUNT) ? 10'(i + 1) : 10'(FREE_HEAD);
			link_prev[i] = (i == 2) ? 10'(FREE_HEAD) : 10'(i - 1);
		end
		slot_value[FREE_HEAD] = SENT;
		slot_value[USED_HEAD] = SENT;
		link_next[FREE_HEAD] = 10'd2;
		link_prev[FREE_HEAD] = 10'(SLOT_COUNT - 1);
		link_next[USED_HEAD] = 10'(USED_HEAD);
		link_prev[USED_HEAD] = 10'(USED_HEAD);
		live_count = 0;

		// Directed items: act, slot, ins_value, steps, list_index, typed, reply
		script = '{
			// sentinels read back the fixed pattern, other slots start at zero
			'{ACT_READ, 10'd0, 32'd0, 11'sd0, 10'd0, 1'b1,
				'{10'd0, SENT, 10'd0, ST_OK}},
			'{ACT_READ, 10'd1, 32'd0, 11'sd0, 10'd0, 1'b1,
				'{10'd1, SENT, 10'd0, ST_OK}},
			'{ACT_READ, 10'd1023, 32'd0, 11'sd0, 10'd0, 1'b1,
				'{10'd1023, 32'd0, 10'd0, ST_OK}},
			// index into an empty list lands on the used sentinel
			'{ACT_INDEX, 10'd0, 32'd0, 11'sd0, 10'd0, 1'b1,
				'{10'd1, SENT, 10'd0, ST_OK}},
			// sentinel removes are refused
			'{ACT_REMOVE, 10'd0, 32'd0, 11'sd0, 10'd0, 1'b1,
				'{10'd0, 32'd0, 10'd0, ST_SENTINEL}},
			'{ACT_REMOVE, 10'd1, 32'd0, 11'sd0, 10'd0, 1'b1,
				'{10'd0, 32'd0, 10'd0, ST_SENTINEL}},
			// remove of a free slot with the count at zero: count holds at zero
			'{ACT_REMOVE, 10'd700, 32'd0, 11'sd0, 10'd0, 1'b1,
				'{10'd0, 32'd0, 10'd0, ST_OK}},
			// appends and a head insert take slots 2, 3, 4 in order
			'{ACT_INSERT, 10'd1, 32'h7FFF_FFFF, 11'sd0, 10'd0, 1'b1,
				'{10'd2, 32'd0, 10'd1, ST_OK}},
			'{ACT_INSERT, 10'd1, 32'h8000_0000, 11'sd0, 10'd0, 1'b1,
				'{10'd3, 32'd0, 10'd2, ST_OK}},
			'{ACT_INSERT, 10'd2, 32'hFFFF_FFFF, 11'sd0, 10'd0, 1'b1,
				'{10'd4, 32'd0, 10'd3, ST_OK}},
			'{ACT_INSERT, 10'd3, 32'd0, 11'sd0, 10'd0, 1'b0, NO_WANT},
			'{ACT_READ, 10'd2, 32'd0, 11'sd0, 10'd0, 1'b0, NO_WANT},
			// longest walks both ways; 11'h400 is minus 1024
			'{ACT_WALK, 10'd2, 32'd0, 11'sd1023, 10'd0, 1'b0, NO_WANT},
			'{ACT_WALK, 10'd3, 32'd0, 11'h400, 10'd0, 1'b0, NO_WANT},
			'{ACT_WALK, 10'd4, 32'd0, -11'sd1, 10'd0, 1'b0, NO_WANT},
			'{ACT_WALK, 10'd5, 32'd0, 11'sd0, 10'd0, 1'b0, NO_WANT},
			'{ACT_INDEX, 10'd0, 32'd0, 11'sd0, 10'd1023, 1'b0, NO_WANT},
			'{ACT_INDEX, 10'd0, 32'd0, 11'sd0, 10'd2, 1'b0, NO_WANT},
			// unknown actions with every field bit set: no change, count only
			'{ACT_RSVD5, 10'd1023, 32'hFFFF_FFFF, 11'h7FF, 10'd1023, 1'b1,
				'{10'd0, 32'd0, 10'd4, ST_OK}},
			'{ACT_RSVD6, 10'd1023, 32'hFFFF_FFFF, 11'h7FF, 10'd1023, 1'b1,
				'{10'd0, 32'd0, 10'd4, ST_OK}},
			'{ACT_RSVD7, 10'd1023, 32'hFFFF_FFFF, 11'h7FF, 10'd1023, 1'b1,
				'{10'd0, 32'd0, 10'd4, ST_OK}},
			// insert ahead of a free slot, remove of a free slot, remove of a live one
			'{ACT_INSERT, 10'd900, 32'd1234, 11'sd0, 10'd0, 1'b0, NO_WANT},
			'{ACT_REMOVE, 10'd600, 32'd0, 11'sd0, 10'd0, 1'b0, NO_WANT},
			'{ACT_REMOVE, 10'd3, 32'd0, 11'sd0, 10'd0, 1'b0, NO_WANT}
		};

		// Hold reset, then release it on an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++)
			send_request(script[i]);

		// Mixed traffic on a short list
		repeat (200) issue_random(40, 25);

		// Grow the list with mostly inserts; stop early if inserts bounce off a full list
		for (int guard = 0; full_hits < 6 && guard < 300; guard++)
			issue_random(85, 5);

		// Drain mostly by removes
		repeat (150) issue_random(15, 60);

		// Last stretch back to back on both sides
		gaps_on = 1'b0;
		repeat (76) issue_random(35, 35);
		s_axis_tvalid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/idll_pkg.sv
rtl/idll_ram.sv
rtl/idll_ctrl.sv
rtl/indexed_doubly_linked_list_engine.sv
rtl/idll_chk.sv
tb/tb_top.sv
